### hw/rtl/piecewise_linear_gray_stretch_assert.svh
// Assertion macros used by the gray stretch checker
`ifndef PIECEWISE_LINEAR_GRAY_STRETCH_ASSERT_SVH
`define PIECEWISE_LINEAR_GRAY_STRETCH_ASSERT_SVH

// check consequent in the same cycle, skipped while in reset
`define PWLGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwlgs check failed");

// check consequent in the next cycle, skipped while in reset
`define PWLGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwlgs check failed");

// check consequent in the next cycle, reset included
`define PWLGS_ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pwlgs check failed");

`endif

### hw/rtl/pwlgs_pkg.sv
// Types, constants and divider step for the piecewise linear gray stretch
package pwlgs_pkg;

    localparam int PIX_W = 8;
    localparam int QUO_W = 8;
    localparam int NUM_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic [PIX_W-1:0] RST_LOW_KNEE_IN = 8'd72;
    localparam logic [PIX_W-1:0] RST_HIGH_KNEE_IN = 8'd100;
    localparam logic [PIX_W-1:0] RST_LOW_KNEE_OUT = 8'd5;
    localparam logic [PIX_W-1:0] RST_HIGH_KNEE_OUT = 8'd240;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_KNEE_IN = 8'd0,
        CFG_HIGH_KNEE_IN = 8'd1,
        CFG_LOW_KNEE_OUT = 8'd2,
        CFG_HIGH_KNEE_OUT = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] low_knee_in;
        logic [PIX_W-1:0] high_knee_in;
        logic [PIX_W-1:0] low_knee_out;
        logic [PIX_W-1:0] high_knee_out;
    } t_knees;

    typedef struct packed {
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] dx;
        logic signed [PIX_W:0] slope;
    } t_ops;

    typedef struct packed {
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } t_div;

    function automatic t_div div_step(input t_div s);
        t_div r;
        logic [PIX_W:0] t;
        logic [PIX_W:0] d;
        r = s;
        t = {s.rem, s.low[PIX_W-1]};
        d = t - {1'b0, s.den};
        if (t >= {1'b0, s.den}) begin
            r.rem = d[PIX_W-1:0];
            r.quo = {s.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = t[PIX_W-1:0];
            r.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        r.low = {s.low[PIX_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

### hw/rtl/pwlgs_if.sv
// Stream and configuration channel interfaces
interface pwlgs_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface pwlgs_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    modport source (output valid, output pixel_out, input ready);
    modport sink (input valid, input pixel_out, output ready);
endinterface

interface pwlgs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### hw/rtl/pwlgs_cfg_regs.sv
// Knee configuration registers
module pwlgs_cfg_regs
    import pwlgs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pwlgs_cfg_if.sink     i_cfg,
    output t_knees        o_knees
);

    t_knees r_knees;
    t_knees n_knees;

    assign i_cfg.ready = 1'b1;
    assign o_knees = r_knees;

    always_comb begin
        n_knees = r_knees;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LOW_KNEE_IN:   n_knees.low_knee_in = i_cfg.wdata;
                CFG_HIGH_KNEE_IN:  n_knees.high_knee_in = i_cfg.wdata;
                CFG_LOW_KNEE_OUT:  n_knees.low_knee_out = i_cfg.wdata;
                CFG_HIGH_KNEE_OUT: n_knees.high_knee_out = i_cfg.wdata;
                default:           n_knees = r_knees;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knees.low_knee_in <= RST_LOW_KNEE_IN;
            r_knees.high_knee_in <= RST_HIGH_KNEE_IN;
            r_knees.low_knee_out <= RST_LOW_KNEE_OUT;
            r_knees.high_knee_out <= RST_HIGH_KNEE_OUT;
        end else begin
            r_knees <= n_knees;
        end
    end

endmodule

### hw/rtl/pwlgs_setup.sv
// Segment select stage: picks base, divisor, offset and slope
module pwlgs_setup
    import pwlgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_knees           i_knees,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_valid,
    input  logic             i_ready,
    output t_ops             o_ops
);

    logic r_vld;
    t_ops r_ops;
    t_ops n_ops;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_ops = r_ops;

    always_comb begin
        priority if (i_pixel < i_knees.low_knee_in) begin
            n_ops.base = '0;
            n_ops.den = i_knees.low_knee_in;
            n_ops.dx = i_pixel;
            n_ops.slope = $signed({1'b0, i_knees.low_knee_out});
        end else if (i_pixel > i_knees.high_knee_in) begin
            n_ops.base = i_knees.high_knee_out;
            n_ops.den = PIX_MAX - i_knees.high_knee_in;
            n_ops.dx = i_pixel - i_knees.high_knee_in;
            n_ops.slope = $signed({1'b0, PIX_MAX - i_knees.high_knee_out});
        end else if (i_knees.high_knee_in == i_knees.low_knee_in) begin
            n_ops.base = i_knees.high_knee_out;
            n_ops.den = {{(PIX_W-1){1'b0}}, 1'b1};
            n_ops.dx = '0;
            n_ops.slope = '0;
        end else begin
            n_ops.base = i_knees.low_knee_out;
            n_ops.den = i_knees.high_knee_in - i_knees.low_knee_in;
            n_ops.dx = i_pixel - i_knees.low_knee_in;
            n_ops.slope = $signed({1'b0, i_knees.high_knee_out})
                        - $signed({1'b0, i_knees.low_knee_out});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ops <= n_ops;
        end
    end

endmodule

### hw/rtl/pwlgs_mac.sv
// Multiply stage and numerator sum stage
module pwlgs_mac
    import pwlgs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_ops  i_ops,
    output logic  o_valid,
    input  logic  i_ready,
    output t_div  o_div
);

    localparam int PROD_W = 2 * (PIX_W + 1);

    logic                     r_vld_m;
    logic                     r_vld_s;
    logic                     ready_s;
    logic [NUM_W-1:0]         r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic [PIX_W-1:0]         r_den_m;
    logic signed [PROD_W-1:0] sum;
    t_div                     r_div;
    t_div                     n_div;

    assign ready_s = !r_vld_s || i_ready;
    assign o_ready = !r_vld_m || ready_s;
    assign o_valid = r_vld_s;
    assign o_div = r_div;

    assign sum = $signed({{(PROD_W-NUM_W){1'b0}}, r_p0}) + r_p1;

    always_comb begin
        n_div.den = r_den_m;
        n_div.quo = '0;
        if (sum[PROD_W-1] || sum == '0) begin
            n_div.rem = '0;
            n_div.low = '0;
        end else begin
            n_div.rem = sum[NUM_W-1:PIX_W];
            n_div.low = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= 1'b0;
            r_vld_s <= 1'b0;
        end else begin
            if (o_ready) begin
                r_vld_m <= i_valid;
            end
            if (ready_s) begin
                r_vld_s <= r_vld_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_p0 <= i_ops.base * i_ops.den;
            r_p1 <= PROD_W'($signed({1'b0, i_ops.dx}) * i_ops.slope);
            r_den_m <= i_ops.den;
        end
        if (ready_s && r_vld_m) begin
            r_div <= n_div;
        end
    end

endmodule

### hw/rtl/pwlgs_div_stage.sv
// One restoring divider stage, QBITS quotient bits per cycle unless stalled
module pwlgs_div_stage
    import pwlgs_pkg::*;
#(
    parameter int QBITS = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_div  i_div,
    output logic  o_valid,
    input  logic  i_ready,
    output t_div  o_div
);

    logic r_vld;
    t_div r_div;
    t_div n_div;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_div = r_div;

    always_comb begin
        n_div = i_div;
        for (int k = 0; k < QBITS; k++) begin
            n_div = div_step(n_div);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

endmodule

### hw/rtl/piecewise_linear_gray_stretch.sv
// Top level of the piecewise linear gray stretch pipeline
//
//  channel | dir | payload              | width
//  i_cfg   | in  | index, wdata         | 8, 8
//  i_pix   | in  | pixel_in             | 8
//  o_pix   | out | pixel_out            | 8
//
// One pixel enters per cycle while the output keeps accepting; the stages, in order, are:
// segment select, multiply, numerator sum, then the divider stages.
// Each stage holds its own valid bit and stalls only when full and blocked downstream.
// Synchronous reset empties the pipeline and loads the default knees.
// Config writes are always accepted; ready is held high.
module piecewise_linear_gray_stretch
    import pwlgs_pkg::*;
#(
    parameter int QBITS_PER_STAGE = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pwlgs_cfg_if.sink      i_cfg,
    pwlgs_pix_in_if.sink   i_pix,
    pwlgs_pix_out_if.source o_pix
);

    localparam int NUM_DIV = QUO_W / QBITS_PER_STAGE;

    t_knees knees;
    logic   setup_valid;
    logic   setup_ready;
    t_ops   ops;
    logic   mac_valid;
    t_div   mac_div;
    logic   div_valid [NUM_DIV+1];
    logic   div_ready [NUM_DIV+1];
    t_div   div_data  [NUM_DIV+1];

    pwlgs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_knees (knees)
    );

    pwlgs_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_knees (knees),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_pixel (i_pix.pixel_in),
        .o_valid (setup_valid),
        .i_ready (setup_ready),
        .o_ops   (ops)
    );

    pwlgs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (setup_valid),
        .o_ready (setup_ready),
        .i_ops   (ops),
        .o_valid (mac_valid),
        .i_ready (div_ready[0]),
        .o_div   (mac_div)
    );

    assign div_valid[0] = mac_valid;
    assign div_data[0] = mac_div;

    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        pwlgs_div_stage #(
            .QBITS (QBITS_PER_STAGE)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_ready (div_ready[g]),
            .i_div   (div_data[g]),
            .o_valid (div_valid[g+1]),
            .i_ready (div_ready[g+1]),
            .o_div   (div_data[g+1])
        );
    end

    assign div_ready[NUM_DIV] = o_pix.ready;
    assign o_pix.valid = div_valid[NUM_DIV];
    assign o_pix.pixel_out = div_data[NUM_DIV].quo;

endmodule

### hw/rtl/pwlgs_checker.sv
// Port level checks for the gray stretch, with its bind
`include "piecewise_linear_gray_stretch_assert.svh"

module pwlgs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_pixel,
    input logic       i_cfg_ready
);

    logic [4:0] r_cnt;
    logic       in_acc;
    logic       out_acc;

    assign in_acc = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {4'd0, in_acc} - {4'd0, out_acc};
        end
    end

    `PWLGS_ASSERT_IMPL(a_cfg_ready, i_clk, i_rst_n, 1'b1, i_cfg_ready)
    `PWLGS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_pixel))
    `PWLGS_ASSERT_IMPL(a_out_owed, i_clk, i_rst_n, i_out_valid, r_cnt != 5'd0)
    `PWLGS_ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, r_cnt == 5'd0, i_in_ready)
    `PWLGS_ASSERT_NEXT_ALL(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind piecewise_linear_gray_stretch pwlgs_checker u_pwlgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.pixel_out),
    .i_cfg_ready (i_cfg.ready)
);

### sim/piecewise_linear_gray_stretch_test.sv
// Self-checking stream testbench for the piecewise linear gray stretch pipeline
module piecewise_linear_gray_stretch_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pwlgs_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(CFG_HIGH_KNEE_OUT + 1);
    localparam logic [CFG_IDX_W-1:0] LAST_IDX = {CFG_IDX_W{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pwlgs_cfg_if cfg_ch ();
    pwlgs_pix_in_if pix_in_ch ();
    pwlgs_pix_out_if pix_out_ch ();

    piecewise_linear_gray_stretch dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_in_ch),
        .o_pix   (pix_out_ch)
    );

    logic [PIX_W-1:0] pending_pixels[$];
    logic [PIX_W-1:0] stretched_pixels[$];
    t_knees knees;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int hold_trig = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [PIX_W-1:0] stretch_gray(input logic [PIX_W-1:0] x,
                                                      input t_knees k);
        int xi, li, hi, lo, ho, num, den, y;
        xi = int'(x);
        li = int'(k.low_knee_in);
        hi = int'(k.high_knee_in);
        lo = int'(k.low_knee_out);
        ho = int'(k.high_knee_out);
        if (xi < li) begin
            num = xi * lo;
            den = li;
        end else if (xi > hi) begin
            den = PIX_MAX - hi;
            num = ho * den + (xi - hi) * (PIX_MAX - ho);
        end else if (hi == li) begin
            num = ho;
            den = 1;
        end else begin
            den = hi - li;
            num = lo * den + (xi - li) * (ho - lo);
        end
        if (den <= 0 || num <= 0) begin
            return '0;
        end
        y = num / den;
        if (y > PIX_MAX) begin
            y = int'(PIX_MAX);
        end
        return y[PIX_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in_ch.valid <= 1'b0;
        end else begin
            if (pix_in_ch.valid && pix_in_ch.ready) begin
                stretched_pixels.insert(stretched_pixels.size(),
                                        stretch_gray(pix_in_ch.pixel_in, knees));
            end
            if (!pix_in_ch.valid || pix_in_ch.ready) begin
                if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pix_in_ch.valid <= 1'b1;
                    pix_in_ch.pixel_in <= pending_pixels.pop_front();
                end else begin
                    pix_in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic [PIX_W-1:0] want;
        if (i_rst_n) begin
            if (pix_out_ch.valid && pix_out_ch.ready) begin
                if (stretched_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected pixel_out %0d with no request pending",
                                 pix_out_ch.pixel_out);
                    end
                end else begin
                    want = stretched_pixels.pop_front();
                    if (pix_out_ch.pixel_out !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("pixel_out mismatch: expected %0d, got %0d",
                                     want, pix_out_ch.pixel_out);
                        end
                    end
                end
            end
            pix_out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_trig) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_LOW_KNEE_IN: knees.low_knee_in = data;
            CFG_HIGH_KNEE_IN: knees.high_knee_in = data;
            CFG_LOW_KNEE_OUT: knees.low_knee_out = data;
            CFG_HIGH_KNEE_OUT: knees.high_knee_out = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_pixels.size() > 0 || pix_in_ch.valid || stretched_pixels.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [PIX_W-1:0] li, input logic [PIX_W-1:0] hi,
                             input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] ho);
        drain();
        @(posedge i_clk);
        write_reg(CFG_LOW_KNEE_IN, li);
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)), PIX_W'($urandom));
        write_reg(CFG_HIGH_KNEE_IN, hi);
        write_reg(CFG_LOW_KNEE_OUT, lo);
        write_reg(CFG_HIGH_KNEE_OUT, ho);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int a, b, v;
        logic [PIX_W-1:0] base;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        pix_in_ch.valid = 1'b0;
        pix_in_ch.pixel_in = '0;
        pix_out_ch.ready = 1'b0;
        knees = '{low_knee_in: RST_LOW_KNEE_IN, high_knee_in: RST_HIGH_KNEE_IN,
                  low_knee_out: RST_LOW_KNEE_OUT, high_knee_out: RST_HIGH_KNEE_OUT};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        pending_pixels = '{8'd0, 8'd255, 8'd71, 8'd72, 8'd73, 8'd99, 8'd100, 8'd101};
        configure(8'd128, 8'd128, 8'd30, 8'd200);
        pending_pixels = '{8'd127, 8'd128, 8'd129};
        configure(8'd0, 8'd255, 8'd77, 8'd166);
        pending_pixels = '{8'd0, 8'd128, 8'd255};
        configure(8'd200, 8'd50, 8'd90, 8'd20);
        pending_pixels = '{8'd199, 8'd200, 8'd100};
        configure(8'd60, 8'd180, 8'd0, 8'd0);
        pending_pixels = '{8'd59, 8'd120, 8'd181};
        configure(8'd60, 8'd180, 8'd255, 8'd255);
        pending_pixels = '{8'd0, 8'd59, 8'd255};

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: configure(8'd0, 8'd0, 8'd0, 8'd0);
                1: configure(8'd255, 8'd255, 8'd255, 8'd255);
                2: begin
                    a = $urandom_range(0, 255);
                    configure(PIX_W'(a), PIX_W'(a), PIX_W'($urandom), PIX_W'($urandom));
                end
                default: begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                    if ($urandom_range(0, 4) != 0 && a > b) begin
                        v = a;
                        a = b;
                        b = v;
                    end
                    configure(PIX_W'(a), PIX_W'(b), PIX_W'($urandom), PIX_W'($urandom));
                end
            endcase
            case (p % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                3: begin send_idle_pct = 36; recv_stall_pct = 36; end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_trig++;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    base = $urandom_range(0, 1) ? knees.low_knee_in : knees.high_knee_in;
                    v = int'(base) + int'($urandom_range(0, 4)) - 2;
                    v = (v < 0) ? 0 : (v > PIX_MAX) ? int'(PIX_MAX) : v;
                    pending_pixels.insert(pending_pixels.size(), v[PIX_W-1:0]);
                end else begin
                    pending_pixels.insert(pending_pixels.size(),
                                          PIX_W'($urandom_range(0, 255)));
                end
            end
        end
        drain();

        if (mismatches == 0 && stretched_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pwlgs_pkg.sv
hw/rtl/pwlgs_if.sv
hw/rtl/pwlgs_cfg_regs.sv
hw/rtl/pwlgs_setup.sv
hw/rtl/pwlgs_mac.sv
hw/rtl/pwlgs_div_stage.sv
hw/rtl/piecewise_linear_gray_stretch.sv
hw/rtl/pwlgs_checker.sv
sim/piecewise_linear_gray_stretch_test.sv
